[rtl/sms_pkg.sv]
// ----------------------------------------------------------------------------
// sms_pkg: shared types and constants for the SELL-4 sparse matrix-vector unit
// Transfer payloads, request codes, lane control and the normalizer request.
// ----------------------------------------------------------------------------
package sms_pkg;

    localparam int LANES       = 4;
    localparam int COL_W       = 12;
    localparam int SLICE_W     = 10;
    localparam int DBL_W       = 64;
    localparam int X_DEPTH_DEF = 4096;
    localparam int NEXP_W      = 14;
    localparam int NMANT_W     = 128;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_BEGIN = 2'd1;
    localparam logic [1:0] REQ_CHUNK = 2'd2;

    localparam logic [DBL_W-1:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [SLICE_W-1:0] slice_index;
        logic [COL_W-1:0]   col0;
        logic [COL_W-1:0]   col1;
        logic [COL_W-1:0]   col2;
        logic [COL_W-1:0]   col3;
        logic [DBL_W-1:0]   val0;
        logic [DBL_W-1:0]   val1;
        logic [DBL_W-1:0]   val2;
        logic [DBL_W-1:0]   val3;
        logic               last_chunk;
    } sms_req_t;

    typedef struct packed {
        logic [SLICE_W-1:0] out_slice;
        logic [DBL_W-1:0]   y0;
        logic [DBL_W-1:0]   y1;
        logic [DBL_W-1:0]   y2;
        logic [DBL_W-1:0]   y3;
    } sms_rsp_t;

    typedef struct packed {
        logic load;
        logic init;
        logic start;
    } sms_lane_ctl_t;

    // value = mant / 2^127 * 2^(expo - 1023), plus sticky below bit 0
    typedef struct packed {
        logic                     sign;
        logic                     zero_sign;
        logic signed [NEXP_W-1:0] expo;
        logic [NMANT_W-1:0]       mant;
        logic                     sticky;
    } sms_norm_req_t;

endpackage

[rtl/sms_norm.sv]
// ----------------------------------------------------------------------------
// sms_norm: iterative normalize and round to IEEE double
// Shifts the wide significand by 8 or 1 bit a cycle, then rounds to nearest even.
// ----------------------------------------------------------------------------
module sms_norm (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  sms_pkg::sms_norm_req_t req,
    output logic                  done,
    output logic [63:0]           result
);
    import sms_pkg::*;

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic                     s_reg, zs_reg, st_reg;
    logic signed [NEXP_W-1:0] e_reg;
    logic [NMANT_W-1:0]       m_reg;
    logic [63:0]              res_reg;

    logic        is_zero, go_right, go_left, finish;
    logic [10:0] enc;
    logic        inc, ovf;
    logic [62:0] rounded;

    always_comb
    begin
        is_zero  = (m_reg == '0) && !st_reg;
        go_right = !is_zero && (e_reg < 14'sd1);
        go_left  = !is_zero && !go_right && !m_reg[NMANT_W-1] && (e_reg > 14'sd1);
        finish   = busy_reg && !go_right && !go_left;
        enc      = m_reg[NMANT_W-1] ? e_reg[10:0] : 11'd0;
        ovf      = m_reg[NMANT_W-1] && (e_reg > 14'sd2046);
        inc      = m_reg[74] & (m_reg[75] | (|m_reg[73:0]) | st_reg);
        rounded  = {enc, m_reg[126:75]} + 63'(inc);
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
            busy_next = 1'b1;
        else if (finish)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s_reg  <= req.sign;
            zs_reg <= req.zero_sign;
            e_reg  <= req.expo;
            m_reg  <= req.mant;
            st_reg <= req.sticky;
        end
        else if (busy_reg)
        begin
            if (is_zero)
                res_reg <= {zs_reg, 63'd0};
            else if (go_right)
            begin
                if (e_reg <= -14'sd120)
                begin
                    // everything lands below the round bit
                    st_reg <= st_reg | (|m_reg);
                    m_reg  <= '0;
                    e_reg  <= 14'sd1;
                end
                else if (e_reg <= -14'sd7)
                begin
                    st_reg <= st_reg | (|m_reg[7:0]);
                    m_reg  <= m_reg >> 8;
                    e_reg  <= e_reg + 14'sd8;
                end
                else
                begin
                    st_reg <= st_reg | m_reg[0];
                    m_reg  <= m_reg >> 1;
                    e_reg  <= e_reg + 14'sd1;
                end
            end
            else if (go_left)
            begin
                if ((m_reg[127:120] == 8'd0) && (e_reg > 14'sd8))
                begin
                    m_reg <= m_reg << 8;
                    e_reg <= e_reg - 14'sd8;
                end
                else
                begin
                    m_reg <= m_reg << 1;
                    e_reg <= e_reg - 14'sd1;
                end
            end
            else if (ovf)
                res_reg <= {s_reg, 11'h7FF, 52'd0};
            else
                res_reg <= {s_reg, rounded};
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

[rtl/sms_lane.sv]
// ----------------------------------------------------------------------------
// sms_lane: one accumulation lane, acc = acc + val * x[col]
// Own copy of the x store, 27x27 partial-product multiplier, aligner, adder.
// ----------------------------------------------------------------------------
module sms_lane #(
    parameter int X_DEPTH = sms_pkg::X_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sms_pkg::sms_lane_ctl_t        ctl,
    input  logic [sms_pkg::COL_W-1:0]     col,
    input  logic [sms_pkg::DBL_W-1:0]     val,
    output logic [sms_pkg::DBL_W-1:0]     acc,
    output logic                          done
);
    import sms_pkg::*;

    localparam int XAW  = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;
    localparam int EXTW = ((XAW > COL_W) ? XAW : COL_W) + 1;

    localparam logic [2:0] L_IDLE  = 3'd0;
    localparam logic [2:0] L_UNPK  = 3'd1;
    localparam logic [2:0] L_MUL   = 3'd2;
    localparam logic [2:0] L_MULN  = 3'd3;
    localparam logic [2:0] L_MULW  = 3'd4;
    localparam logic [2:0] L_ALIGN = 3'd5;
    localparam logic [2:0] L_SUM   = 3'd6;
    localparam logic [2:0] L_ADDW  = 3'd7;

    function automatic logic f_nan(input logic [63:0] d);
        return (&d[62:52]) && (|d[51:0]);
    endfunction

    function automatic logic f_inf(input logic [63:0] d);
        return (&d[62:52]) && !(|d[51:0]);
    endfunction

    function automatic logic f_zero(input logic [63:0] d);
        return d[62:0] == 63'd0;
    endfunction

    function automatic logic [63:0] f_quiet(input logic [63:0] d);
        return d | 64'h0008_0000_0000_0000;
    endfunction

    function automatic logic [10:0] f_exp(input logic [63:0] d);
        return (d[62:52] == 11'd0) ? 11'd1 : d[62:52];
    endfunction

    function automatic logic [52:0] f_sig(input logic [63:0] d);
        return {|d[62:52], d[51:0]};
    endfunction

    logic [DBL_W-1:0] x_mem [X_DEPTH];

    logic [EXTW-1:0] col_ext;
    logic            in_range;
    logic [XAW-1:0]  x_addr;

    logic [2:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       done_reg, done_next;

    logic [63:0]              val_reg, x_rd_reg, prod_reg, acc_reg;
    logic                     inr_reg;
    logic [52:0]              ma_reg, mb_reg;
    logic                     mul_s_reg;
    logic signed [NEXP_W-1:0] mul_e_reg;
    logic [53:0]              pp_reg;
    logic [5:0]               pp_sh_reg;
    logic [105:0]             prod_acc_reg;
    logic [127:0]             big_reg, small_reg;
    logic                     add_st_reg, add_sub_reg, add_s_reg;
    logic signed [NEXP_W-1:0] add_e_reg;

    logic [63:0] mul_b, mul_spec_val, add_spec_val;
    logic        mul_spec, add_spec;
    logic [26:0] opa, opb;
    logic [5:0]  op_sh;

    logic [10:0]  ea, eb, e_big, e_small, e_dist;
    logic [52:0]  sa_m, sb_m, m_big, m_small;
    logic         a_big;
    logic [127:0] small_ext, small_sh, lost_mask;
    logic         small_st;
    logic [127:0] sum_m;

    logic          norm_start, norm_done;
    logic [63:0]   norm_res;
    sms_norm_req_t norm_req;

    assign col_ext  = EXTW'(col);
    assign in_range = col_ext < EXTW'(X_DEPTH);
    assign x_addr   = col_ext[XAW-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.load && in_range)
            x_mem[x_addr] <= val;
        if (ctl.start)
            x_rd_reg <= x_mem[x_addr];
    end

    // product operands; out-of-range columns read as +0
    assign mul_b = inr_reg ? x_rd_reg : 64'd0;

    always_comb
    begin
        mul_spec     = 1'b1;
        mul_spec_val = 64'd0;
        if (f_nan(val_reg))
            mul_spec_val = f_quiet(val_reg);
        else if (f_nan(mul_b))
            mul_spec_val = f_quiet(mul_b);
        else if ((f_inf(val_reg) && f_zero(mul_b)) || (f_inf(mul_b) && f_zero(val_reg)))
            mul_spec_val = DEFAULT_NAN;
        else if (f_inf(val_reg) || f_inf(mul_b))
            mul_spec_val = {val_reg[63] ^ mul_b[63], 11'h7FF, 52'd0};
        else
            mul_spec = 1'b0;
    end

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:
            begin
                opa = ma_reg[26:0];
                opb = mb_reg[26:0];
                op_sh = 6'd0;
            end
            2'd1:
            begin
                opa = ma_reg[26:0];
                opb = {1'b0, mb_reg[52:27]};
                op_sh = 6'd27;
            end
            2'd2:
            begin
                opa = {1'b0, ma_reg[52:27]};
                opb = mb_reg[26:0];
                op_sh = 6'd27;
            end
            2'd3:
            begin
                opa = {1'b0, ma_reg[52:27]};
                opb = {1'b0, mb_reg[52:27]};
                op_sh = 6'd54;
            end
            default:
            begin
                opa = '0;
                opb = '0;
                op_sh = 6'd0;
            end
        endcase
    end

    // accumulator is the first addend
    always_comb
    begin
        add_spec     = 1'b1;
        add_spec_val = acc_reg;
        if (f_nan(acc_reg))
            add_spec_val = f_quiet(acc_reg);
        else if (f_nan(prod_reg))
            add_spec_val = f_quiet(prod_reg);
        else if (f_inf(acc_reg) && f_inf(prod_reg) && (acc_reg[63] != prod_reg[63]))
            add_spec_val = DEFAULT_NAN;
        else if (f_inf(acc_reg))
            add_spec_val = acc_reg;
        else if (f_inf(prod_reg))
            add_spec_val = prod_reg;
        else
            add_spec = 1'b0;
    end

    always_comb
    begin
        ea        = f_exp(acc_reg);
        eb        = f_exp(prod_reg);
        sa_m      = f_sig(acc_reg);
        sb_m      = f_sig(prod_reg);
        a_big     = {ea, sa_m} >= {eb, sb_m};
        e_big     = a_big ? ea : eb;
        e_small   = a_big ? eb : ea;
        m_big     = a_big ? sa_m : sb_m;
        m_small   = a_big ? sb_m : sa_m;
        e_dist    = e_big - e_small;
        small_ext = {1'b0, m_small, 74'd0};
        lost_mask = (128'd1 << e_dist[6:0]) - 128'd1;
        if (e_dist >= 11'd128)
        begin
            small_sh = '0;
            small_st = |m_small;
        end
        else
        begin
            small_sh = small_ext >> e_dist[6:0];
            small_st = |(small_ext & lost_mask);
        end
    end

    assign sum_m = add_sub_reg ? (big_reg - small_reg - 128'(add_st_reg))
                               : (big_reg + small_reg);

    always_comb
    begin
        if (state_reg == L_SUM)
        begin
            norm_req.sign      = add_s_reg;
            norm_req.zero_sign = add_sub_reg ? 1'b0 : add_s_reg;
            norm_req.expo      = add_e_reg;
            norm_req.mant      = sum_m;
            norm_req.sticky    = add_st_reg;
        end
        else
        begin
            norm_req.sign      = mul_s_reg;
            norm_req.zero_sign = mul_s_reg;
            norm_req.expo      = mul_e_reg;
            norm_req.mant      = {prod_acc_reg, 22'd0};
            norm_req.sticky    = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        norm_start = 1'b0;
        case (state_reg)
            L_IDLE:
                if (ctl.start)
                    state_next = L_UNPK;
            L_UNPK:
            begin
                cnt_next   = 3'd0;
                state_next = mul_spec ? L_ALIGN : L_MUL;
            end
            L_MUL:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                    state_next = L_MULN;
            end
            L_MULN:
            begin
                norm_start = 1'b1;
                state_next = L_MULW;
            end
            L_MULW:
                if (norm_done)
                    state_next = L_ALIGN;
            L_ALIGN:
                if (add_spec)
                begin
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end
                else
                    state_next = L_SUM;
            L_SUM:
            begin
                norm_start = 1'b1;
                state_next = L_ADDW;
            end
            L_ADDW:
                if (norm_done)
                begin
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end
            default:
                state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= 3'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.init)
            acc_reg <= val;
        if (ctl.start)
        begin
            val_reg <= val;
            inr_reg <= in_range;
        end
        case (state_reg)
            L_UNPK:
            begin
                prod_reg     <= mul_spec_val;
                ma_reg       <= f_sig(val_reg);
                mb_reg       <= f_sig(mul_b);
                mul_s_reg    <= val_reg[63] ^ mul_b[63];
                mul_e_reg    <= $signed(14'(f_exp(val_reg)) + 14'(f_exp(mul_b)) - 14'd1022);
                prod_acc_reg <= '0;
            end
            L_MUL:
            begin
                if (cnt_reg != 3'd4)
                begin
                    pp_reg    <= {27'd0, opa} * {27'd0, opb};
                    pp_sh_reg <= op_sh;
                end
                if (cnt_reg != 3'd0)
                    prod_acc_reg <= prod_acc_reg + (106'(pp_reg) << pp_sh_reg);
            end
            L_MULW:
                if (norm_done)
                    prod_reg <= norm_res;
            L_ALIGN:
            begin
                if (add_spec)
                    acc_reg <= add_spec_val;
                big_reg     <= {1'b0, m_big, 74'd0};
                small_reg   <= small_sh;
                add_st_reg  <= small_st;
                add_sub_reg <= acc_reg[63] ^ prod_reg[63];
                add_s_reg   <= a_big ? acc_reg[63] : prod_reg[63];
                add_e_reg   <= $signed(14'(e_big) + 14'd1);
            end
            L_ADDW:
                if (norm_done)
                    acc_reg <= norm_res;
            default:
            begin
            end
        endcase
    end

    sms_norm u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (norm_start),
        .req    (norm_req),
        .done   (norm_done),
        .result (norm_res)
    );

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

[rtl/sell4_sparse_matvec.sv]
// ----------------------------------------------------------------------------
// sell4_sparse_matvec: SELL-4 sparse matrix times vector, y += A*x, double
// Four lanes accumulate one row each; the top level sequences and merges them.
// ----------------------------------------------------------------------------
// Load-x and begin-slice transfers are done as they are accepted. For a matrix
// chunk, each lane forms the double product from four 27x27 partial products
// on one multiplier, then passes the product and the sum through its single
// normalize/round unit; subnormal operands and cancellation need more shift
// steps. The next item is taken once all four lanes finish and, when a slice
// ends, once its result has entered the output register; a finished result
// waits there while later items run. Each lane holds its own X_DEPTH-entry
// copy of x; never-loaded entries read as undefined, columns >= X_DEPTH as +0.
module sell4_sparse_matvec #(
    parameter int X_DEPTH = sms_pkg::X_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  sms_pkg::sms_req_t req_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output sms_pkg::sms_rsp_t rsp_data
);
    import sms_pkg::*;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_RUN  = 2'd1;
    localparam logic [1:0] T_EMIT = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic               open_reg, open_next;
    logic               last_reg, last_next;
    logic [SLICE_W-1:0] slice_reg, slice_next;
    logic [LANES-1:0]   mask_reg, mask_next;
    logic               rsp_valid_reg, rsp_valid_next;
    sms_rsp_t           rsp_reg;

    logic          req_fire, load_out, is_load;
    sms_lane_ctl_t lane_ctl;
    logic [COL_W-1:0] col_v [LANES];
    logic [DBL_W-1:0] val_v [LANES];
    logic [DBL_W-1:0] acc_v [LANES];
    logic [LANES-1:0] lane_done;

    assign req_stall = (state_reg != T_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign is_load   = (req_data.req_type == REQ_LOAD);

    // a load writes the same x entry into every lane's copy
    assign col_v[0] = req_data.col0;
    assign col_v[1] = is_load ? req_data.col0 : req_data.col1;
    assign col_v[2] = is_load ? req_data.col0 : req_data.col2;
    assign col_v[3] = is_load ? req_data.col0 : req_data.col3;
    assign val_v[0] = req_data.val0;
    assign val_v[1] = is_load ? req_data.val0 : req_data.val1;
    assign val_v[2] = is_load ? req_data.val0 : req_data.val2;
    assign val_v[3] = is_load ? req_data.val0 : req_data.val3;

    assign lane_ctl.load  = req_fire && is_load;
    assign lane_ctl.init  = req_fire && (req_data.req_type == REQ_BEGIN);
    assign lane_ctl.start = req_fire && (req_data.req_type == REQ_CHUNK) && open_reg;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        sms_lane #(
            .X_DEPTH (X_DEPTH)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (lane_ctl),
            .col   (col_v[g]),
            .val   (val_v[g]),
            .acc   (acc_v[g]),
            .done  (lane_done[g])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        open_next  = open_reg;
        last_next  = last_reg;
        slice_next = slice_reg;
        mask_next  = mask_reg;
        load_out   = 1'b0;
        case (state_reg)
            T_IDLE:
                if (req_fire)
                begin
                    case (req_data.req_type)
                        REQ_BEGIN:
                        begin
                            // a begin drops any open slice
                            slice_next = req_data.slice_index;
                            open_next  = !req_data.last_chunk;
                            if (req_data.last_chunk)
                                state_next = T_EMIT;
                        end
                        REQ_CHUNK:
                            if (open_reg)
                            begin
                                last_next  = req_data.last_chunk;
                                mask_next  = '0;
                                state_next = T_RUN;
                            end
                        default:
                        begin
                        end
                    endcase
                end
            T_RUN:
            begin
                mask_next = mask_reg | lane_done;
                if (&mask_next)
                begin
                    if (last_reg)
                    begin
                        open_next  = 1'b0;
                        state_next = T_EMIT;
                    end
                    else
                        state_next = T_IDLE;
                end
            end
            T_EMIT:
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    load_out   = 1'b1;
                    state_next = T_IDLE;
                end
            default:
                state_next = T_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load_out)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            open_reg      <= 1'b0;
            last_reg      <= 1'b0;
            slice_reg     <= '0;
            mask_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            last_reg      <= last_next;
            slice_reg     <= slice_next;
            mask_reg      <= mask_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            rsp_reg.out_slice <= slice_reg;
            rsp_reg.y0        <= acc_v[0];
            rsp_reg.y1        <= acc_v[1];
            rsp_reg.y2        <= acc_v[2];
            rsp_reg.y3        <= acc_v[3];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (|lane_done) |-> (state_reg == T_RUN))
        else $error("lane finished outside a chunk");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == T_EMIT) && !(rsp_valid_reg && rsp_stall)) |=> rsp_valid_reg)
        else $error("result not loaded when output was free");

    a_chunk_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req_data.req_type == REQ_CHUNK) && open_reg) |=> (state_reg == T_RUN))
        else $error("chunk on open slice did not start lanes");

    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_RUN) |-> open_reg)
        else $error("lanes running without an open slice");

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the SELL-4 sparse matrix-vector unit
// Loads x, streams begin and chunk items with random idling on both sides,
// and checks every slice result against a double-precision predictor.
// ----------------------------------------------------------------------------
module testbench;
    import sms_pkg::*;

    localparam int XD = X_DEPTH_DEF;
    localparam logic [1:0] REQ_NONE = 2'd3;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    sms_req_t req_data = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    sms_rsp_t rsp_data;

    sell4_sparse_matvec #(.X_DEPTH(XD)) DUT (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [63:0]        x_bits [XD];
    bit                 x_loaded [XD];
    int                 loaded_cols [$];
    logic [63:0]        acc_bits [LANES];
    logic [SLICE_W-1:0] cur_slice = '0;
    bit                 slice_open = 1'b0;

    sms_rsp_t slice_results [$];
    int       errors = 0;
    int       items_sent = 0;
    int       results_seen = 0;
    int       burst_left = 0;
    bit       hold_req = 1'b0;

    function automatic logic [63:0] mul_add(logic [63:0] acc, logic [63:0] v,
                                            logic [63:0] xv);
        real prod;
        real sum;
        prod = $bitstoreal(v) * $bitstoreal(xv);
        sum  = $bitstoreal(acc) + prod;
        return $realtobits(sum);
    endfunction

    function automatic bit is_nan(logic [63:0] b);
        return (b[62:52] == 11'h7FF) && (b[51:0] != 0);
    endfunction

    function automatic sms_rsp_t slice_out();
        sms_rsp_t r;
        r.out_slice = cur_slice;
        r.y0 = acc_bits[0];
        r.y1 = acc_bits[1];
        r.y2 = acc_bits[2];
        r.y3 = acc_bits[3];
        return r;
    endfunction

    task automatic predict_slice(sms_req_t r);
        logic [63:0] v [LANES];
        logic [COL_W-1:0] c [LANES];
        v = '{r.val0, r.val1, r.val2, r.val3};
        c = '{r.col0, r.col1, r.col2, r.col3};
        case (r.req_type)
            REQ_LOAD:
            begin
                x_bits[r.col0] = r.val0;
                if (!x_loaded[r.col0])
                    loaded_cols.push_back(r.col0);
                x_loaded[r.col0] = 1'b1;
            end
            REQ_BEGIN:
            begin
                cur_slice = r.slice_index;
                for (int k = 0; k < LANES; k++)
                    acc_bits[k] = v[k];
                slice_open = !r.last_chunk;
                if (r.last_chunk)
                    slice_results.push_back(slice_out());
            end
            REQ_CHUNK:
            begin
                if (slice_open)
                begin
                    for (int k = 0; k < LANES; k++)
                        acc_bits[k] = mul_add(acc_bits[k], v[k], x_bits[c[k]]);
                    if (r.last_chunk)
                    begin
                        slice_open = 1'b0;
                        slice_results.push_back(slice_out());
                    end
                end
            end
            default: ;
        endcase
    endtask

    // one transfer on the request channel, with burst/gap idling in front
    task automatic send_item(sms_req_t r);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do @(posedge clk); while (req_stall);
        predict_slice(r);
        items_sent++;
    endtask

    function automatic logic [63:0] rand_dbl();
        logic [63:0] b;
        int kind;
        kind = $urandom_range(0, 99);
        b = {$urandom, $urandom};
        if (kind < 75)
            b[62:52] = 11'(1003 + $urandom_range(0, 40));
        else if (kind < 80)
            b[62:0] = '0;
        else if (kind < 85)
            b[62:52] = '0;
        else if (kind < 88)
            b[62:0] = {11'h7FF, 52'h0};
        return b;
    endfunction

    function automatic logic [COL_W-1:0] rand_col();
        return COL_W'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
    endfunction

    function automatic sms_req_t mk_load(logic [COL_W-1:0] a, logic [63:0] v);
        sms_req_t r;
        r = $bits(sms_req_t)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom, $urandom});
        r.req_type = REQ_LOAD;
        r.col0 = a;
        r.val0 = v;
        return r;
    endfunction

    function automatic sms_req_t mk_begin(logic [SLICE_W-1:0] s, bit empty);
        sms_req_t r;
        r = $bits(sms_req_t)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom, $urandom});
        r.req_type = REQ_BEGIN;
        r.slice_index = s;
        r.val0 = rand_dbl();
        r.val1 = rand_dbl();
        r.val2 = rand_dbl();
        r.val3 = rand_dbl();
        r.last_chunk = empty;
        return r;
    endfunction

    function automatic sms_req_t mk_chunk(bit last);
        sms_req_t r;
        r.req_type = REQ_CHUNK;
        r.slice_index = SLICE_W'($urandom);
        r.col0 = rand_col();
        r.col1 = rand_col();
        r.col2 = rand_col();
        r.col3 = rand_col();
        r.val0 = rand_dbl();
        r.val1 = rand_dbl();
        r.val2 = rand_dbl();
        r.val3 = rand_dbl();
        r.last_chunk = last;
        return r;
    endfunction

    task automatic send_slice(int chunks);
        send_item(mk_begin(SLICE_W'($urandom), chunks == 0));
        for (int i = 0; i < chunks; i++)
            send_item(mk_chunk(i == chunks - 1));
    endtask

    task automatic test_directed();
        sms_req_t r;
        send_item(mk_load('0, 64'h3FF0_0000_0000_0000));
        send_item(mk_load('1, 64'hBFF8_0000_0000_0000));
        send_item(mk_load(12'hAAA, 64'h7FEF_FFFF_FFFF_FFFF));
        send_item(mk_load(12'h555, 64'h0000_0000_0000_0001));
        // chunk with no slice open, and an unknown request, both ignored
        send_item(mk_chunk(1'b1));
        r = mk_chunk(1'b1);
        r.req_type = REQ_NONE;
        send_item(r);
        // empty slices at both ends of the slice range
        r = mk_begin('1, 1'b1);
        r.val0 = '1;
        r.val1 = '0;
        r.val2 = 64'h8000_0000_0000_0000;
        r.val3 = 64'h7FF0_0000_0000_0000;
        send_item(r);
        send_item(mk_begin('0, 1'b1));
        // begin while open drops the first slice
        send_item(mk_begin(10'h155, 1'b0));
        send_item(mk_chunk(1'b0));
        send_item(mk_begin(10'h2AA, 1'b0));
        r = mk_chunk(1'b0);
        r.col0 = '0;
        r.col1 = '1;
        r.col2 = 12'hAAA;
        r.col3 = 12'h555;
        r.val0 = '1;
        r.val1 = '0;
        r.val2 = 64'h7FEF_FFFF_FFFF_FFFF;
        r.val3 = 64'h000F_FFFF_FFFF_FFFF;
        send_item(r);
        r.val0 = 64'h4000_0000_0000_0000;
        r.val1 = 64'hFFF0_0000_0000_0000;
        r.last_chunk = 1'b1;
        send_item(r);
        send_slice(1);
        send_slice(3);
    endtask

    task automatic test_random(int n);
        int sent;
        int pick;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                pick = $urandom_range(0, 4);
                send_slice(pick);
                sent += pick + 1;
            end
            else if (pick < 88)
            begin
                send_item(mk_load(COL_W'($urandom), rand_dbl()));
                sent++;
            end
            else if (pick < 93)
            begin
                // abandoned slice
                send_item(mk_begin(SLICE_W'($urandom), 1'b0));
                send_item(mk_chunk(1'b0));
                sent += 2;
            end
            else if (pick < 97)
            begin
                if (!slice_open)
                begin
                    send_item(mk_chunk($urandom_range(0, 1)));
                    sent++;
                end
            end
            else
            begin
                pick = $urandom;
                send_item(sms_req_t'({REQ_NONE, 315'(pick)}));
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 8; i++)
            send_slice($urandom_range(0, 2));
    endtask

    // receiver stall pattern, with a long hold-off on request
    int hold_cnt = 0;
    int stall_mode = 0;
    int mode_left = 0;
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cnt = 400;
        end
        if (mode_left == 0)
        begin
            mode_left  = $urandom_range(8, 80);
            stall_mode = $urandom_range(0, 2);
        end
        mode_left--;
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            rsp_stall <= 1'b1;
        end
        else if (stall_mode == 0)
            rsp_stall <= 1'b0;
        else if (stall_mode == 1)
            rsp_stall <= ($urandom_range(0, 3) == 0);
        else
            rsp_stall <= ($urandom_range(0, 9) < 7);
    end

    function automatic void check_y(string name, logic [63:0] e, logic [63:0] a);
        if (is_nan(e) ? !is_nan(a) : (a !== e))
        begin
            $error("%s mismatch: expected %h, actual %h", name, e, a);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        sms_rsp_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            results_seen++;
            if (slice_results.size() == 0)
            begin
                $error("unexpected result transfer: out_slice %h", rsp_data.out_slice);
                errors++;
            end
            else
            begin
                e = slice_results.pop_front();
                if (rsp_data.out_slice !== e.out_slice)
                begin
                    $error("out_slice mismatch: expected %h, actual %h",
                           e.out_slice, rsp_data.out_slice);
                    errors++;
                end
                check_y("y0", e.y0, rsp_data.y0);
                check_y("y1", e.y1, rsp_data.y1);
                check_y("y2", e.y2, rsp_data.y2);
                check_y("y3", e.y3, rsp_data.y3);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        int waited;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        // spread x over the whole column range before random traffic
        for (int i = 0; i < 40; i++)
            send_item(mk_load(COL_W'($urandom), rand_dbl()));
        test_random(445);
        test_backpressure();
        test_random(30);
        @(negedge clk);
        req_valid <= 1'b0;
        waited = 0;
        while (slice_results.size() != 0 && waited < 200_000)
        begin
            @(posedge clk);
            waited++;
        end
        if (slice_results.size() != 0)
        begin
            $error("%0d expected results never arrived", slice_results.size());
            errors++;
        end
        repeat (100) @(posedge clk);
        $display("Sent %0d items and checked %0d slice results, %0d x entries loaded.",
                 items_sent, results_seen, loaded_cols.size());
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
